// ===== rtl/core/amra_pkg.sv =====
// Shared constants and types for the audio mixer with RMS activity detection.
`default_nettype none
package amra_pkg;

  localparam int CHANNELS_DEF = 4;
  localparam int MAX_CHANNELS = 4;

  localparam int SAMPLE_W = 16;
  localparam int ENERGY_W = 47;
  localparam int COUNT_W  = 16;
  localparam int MS_W     = 31;
  localparam int RMS_W    = 16;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 120;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 31;

  localparam int DIV_STEPS  = 47;
  localparam int SQRT_STEPS = 16;

  localparam logic [COUNT_W-1:0] TICK_LENGTH_RESET = 16'd4800;
  localparam logic [MS_W-1:0]    SPEAK_THR_RESET   = 31'd107374;

  localparam logic [CFG_INDEX_W-1:0] REG_TICK_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEAK_THR   = 2'd1;

  // Job index: 0..3 channels, then the mix, then the peak root.
  localparam logic [2:0] JOB_MIX  = 3'd4;
  localparam logic [2:0] JOB_PEAK = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_LOAD,
    ST_DIV,
    ST_SQRT,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/audio_mixer_rms_activity.sv =====
// Top level of the four-channel audio mixer with per-tick RMS and speaking flags.
`default_nettype none
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_tvalid/s_tready  s_tdata: four samples and present mask
//  m_        out        m_tvalid/m_tready  m_tdata: mix and levels, m_tlast: tick done
//  cfg_      in         cfg_we             cfg_index, cfg_data: register write
//
//  A word that does not end a tick is captured, takes five square-and-accumulate
//  steps through one multiplier, and then waits in the output state. A word that
//  ends a tick adds five restoring divisions (one load plus 47 steps each) and six
//  bit-serial square roots of 16 steps, all on one shared divide/root unit. The
//  input is not ready while a word is in work or while its result waits on m_tready.
//  Reset is synchronous and clears control state, accumulators and the peak.
//
module audio_mixer_rms_activity #(
  parameter int CHANNELS = amra_pkg::CHANNELS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // s_tdata: sample_ch0, sample_ch1, sample_ch2, sample_ch3, present_mask, zero fill
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [amra_pkg::IN_TDATA_W-1:0]     s_tdata,
  // m_tdata: mixed_sample, speaking_mask, rms_ch0, rms_ch1, rms_ch2, rms_ch3,
  //          mix_rms, peak_mix_rms, zero fill
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [amra_pkg::OUT_TDATA_W-1:0]         m_tdata,
  output logic                                     m_tlast,
  input  wire logic                                cfg_we,
  input  wire logic [amra_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [amra_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int NCH = amra_pkg::MAX_CHANNELS;
  localparam int EW  = amra_pkg::ENERGY_W;
  localparam int CW  = amra_pkg::COUNT_W;
  localparam int MW  = amra_pkg::MS_W;
  localparam int RW  = amra_pkg::RMS_W;

  amra_pkg::state_t state, state_next;

  // Configuration registers.
  logic [CW-1:0] tick_length;
  logic [MW-1:0] speak_thr;

  // Captured input word.
  logic signed [15:0] samples [NCH];
  logic [NCH-1:0]     present;
  logic signed [16:0] mix;
  logic [15:0]        mixed_out;

  // Accumulators.
  logic [EW-1:0] energy [NCH];
  logic [CW-1:0] count  [NCH];
  logic [EW-1:0] mix_energy;
  logic [CW-1:0] tick_pos;
  logic [MW-1:0] peak_ms;

  // Sequencer.
  logic [2:0] idx;
  logic [5:0] step;

  // Shared divide/root unit.
  logic [EW-1:0] num;
  logic [CW-1:0] rem;
  logic [CW-1:0] divisor;
  logic [MW-1:0] root_v;
  logic [31:0]   root_res;
  logic [31:0]   root_bit;

  // Results.
  logic [RW-1:0]  rms [NCH];
  logic [RW-1:0]  mix_rms;
  logic [RW-1:0]  peak_rms;
  logic [NCH-1:0] speaking;
  logic           tick_done;

  // Input word mix: sum of present samples, clamped to plus or minus one.
  logic [NCH-1:0]     in_mask;
  logic signed [17:0] in_sum;
  logic signed [16:0] in_mix;
  logic [15:0]        in_scaled;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      in_mask[c] = s_tdata[64 + c] && (c < CHANNELS);
    end
    in_sum = '0;
    for (int c = 0; c < NCH; c++) begin
      if (in_mask[c]) begin
        in_sum = in_sum + 18'(signed'(s_tdata[16*c +: 16]));
      end
    end
    if (in_sum > 18'sd32768) begin
      in_mix = 17'sd32768;
    end else if (in_sum < -18'sd32768) begin
      in_mix = -17'sd32768;
    end else begin
      in_mix = in_sum[16:0];
    end
    // Scaling by 32767/32768 toward zero moves any nonzero value one step to zero.
    if (in_mix > 17'sd0) begin
      in_scaled = 16'(in_mix - 17'sd1);
    end else if (in_mix < 17'sd0) begin
      in_scaled = 16'(in_mix + 17'sd1);
    end else begin
      in_scaled = '0;
    end
  end

  // Square of the selected operand.
  logic signed [16:0] sq_op;
  logic signed [33:0] sq;
  logic [EW-1:0]      sq_ext;

  always_comb begin
    if (idx == amra_pkg::JOB_MIX) begin
      sq_op = mix;
    end else if (present[idx[1:0]]) begin
      sq_op = 17'(samples[idx[1:0]]);
    end else begin
      sq_op = '0;
    end
    sq     = sq_op * sq_op;
    sq_ext = {{(EW-34){1'b0}}, sq};
  end

  // End of tick: position plus one reaches the length, a zero length acts as one.
  logic [CW-1:0] len_eff;
  logic          tick_end;
  assign len_eff  = (tick_length == '0) ? CW'(1) : tick_length;
  assign tick_end = ({1'b0, tick_pos} + 17'd1) >= {1'b0, len_eff};

  // One restoring division step.
  logic [CW:0]   div_trial;
  logic          div_qbit;
  logic [CW-1:0] rem_next;
  logic [EW-1:0] num_next;

  always_comb begin
    div_trial = {rem, num[EW-1]};
    div_qbit  = div_trial >= {1'b0, divisor};
    rem_next  = div_qbit ? CW'(div_trial - {1'b0, divisor}) : div_trial[CW-1:0];
    num_next  = {num[EW-2:0], div_qbit};
  end

  // One square root step.
  logic [31:0] root_trial;
  logic        root_take;
  logic [MW-1:0] root_v_next;
  logic [31:0] root_res_next;

  always_comb begin
    root_trial    = root_res + root_bit;
    root_take     = {1'b0, root_v} >= root_trial;
    root_v_next   = root_take ? MW'({1'b0, root_v} - root_trial) : root_v;
    root_res_next = root_take ? ((root_res >> 1) + root_bit) : (root_res >> 1);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      amra_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = amra_pkg::ST_SQ;
      end
      amra_pkg::ST_SQ: begin
        if (idx == amra_pkg::JOB_MIX) begin
          state_next = tick_end ? amra_pkg::ST_LOAD : amra_pkg::ST_OUT;
        end
      end
      amra_pkg::ST_LOAD: state_next = amra_pkg::ST_DIV;
      amra_pkg::ST_DIV: begin
        if (step == 6'(amra_pkg::DIV_STEPS - 1)) state_next = amra_pkg::ST_SQRT;
      end
      amra_pkg::ST_SQRT: begin
        if (step == 6'(amra_pkg::SQRT_STEPS - 1)) begin
          if (idx < amra_pkg::JOB_MIX) begin
            state_next = amra_pkg::ST_LOAD;
          end else if (idx == amra_pkg::JOB_MIX) begin
            state_next = amra_pkg::ST_SQRT;
          end else begin
            state_next = amra_pkg::ST_OUT;
          end
        end
      end
      amra_pkg::ST_OUT: begin
        if (m_tready) state_next = amra_pkg::ST_IDLE;
      end
      default: state_next = amra_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    s_tready = (state == amra_pkg::ST_IDLE);
    m_tvalid = (state == amra_pkg::ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= amra_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_length <= amra_pkg::TICK_LENGTH_RESET;
      speak_thr   <= amra_pkg::SPEAK_THR_RESET;
    end else if (cfg_we) begin
      if (cfg_index == amra_pkg::REG_TICK_LENGTH) begin
        tick_length <= cfg_data[CW-1:0];
      end else if (cfg_index == amra_pkg::REG_SPEAK_THR) begin
        speak_thr <= cfg_data;
      end
    end
  end

  // Accumulators, sequencer counters and the peak.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NCH; c++) begin
        energy[c] <= '0;
        count[c]  <= '0;
      end
      mix_energy <= '0;
      tick_pos   <= '0;
      peak_ms    <= '0;
      idx        <= '0;
      step       <= '0;
      tick_done  <= 1'b0;
    end else begin
      unique case (state)
        amra_pkg::ST_IDLE: begin
          idx  <= '0;
          step <= '0;
        end
        amra_pkg::ST_SQ: begin
          if (idx == amra_pkg::JOB_MIX) begin
            mix_energy <= mix_energy + sq_ext;
            if (tick_end) begin
              idx <= '0;
            end else begin
              tick_pos  <= tick_pos + CW'(1);
              tick_done <= 1'b0;
            end
          end else begin
            energy[idx[1:0]] <= energy[idx[1:0]] + sq_ext;
            if (present[idx[1:0]]) count[idx[1:0]] <= count[idx[1:0]] + CW'(1);
            idx <= idx + 3'd1;
          end
        end
        amra_pkg::ST_LOAD: begin
          step <= '0;
        end
        amra_pkg::ST_DIV: begin
          if (step == 6'(amra_pkg::DIV_STEPS - 1)) begin
            step <= '0;
            if (idx == amra_pkg::JOB_MIX && num_next[MW-1:0] > peak_ms) begin
              peak_ms <= num_next[MW-1:0];
            end
          end else begin
            step <= step + 6'd1;
          end
        end
        amra_pkg::ST_SQRT: begin
          if (step == 6'(amra_pkg::SQRT_STEPS - 1)) begin
            step <= '0;
            if (idx < amra_pkg::JOB_MIX) begin
              idx <= idx + 3'd1;
            end else if (idx == amra_pkg::JOB_MIX) begin
              idx <= amra_pkg::JOB_PEAK;
            end else begin
              // Tick closed: clear the accumulators for the next one.
              for (int c = 0; c < NCH; c++) begin
                energy[c] <= '0;
                count[c]  <= '0;
              end
              mix_energy <= '0;
              tick_pos   <= '0;
              tick_done  <= 1'b1;
            end
          end else begin
            step <= step + 6'd1;
          end
        end
        amra_pkg::ST_OUT: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Captured word, divide/root unit and result registers.
  always_ff @(posedge clk) begin
    unique case (state)
      amra_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          for (int c = 0; c < NCH; c++) begin
            samples[c] <= signed'(s_tdata[16*c +: 16]);
          end
          present   <= in_mask;
          mix       <= in_mix;
          mixed_out <= in_scaled;
        end
      end
      amra_pkg::ST_LOAD: begin
        rem <= '0;
        if (idx == amra_pkg::JOB_MIX) begin
          num     <= mix_energy;
          divisor <= tick_pos + CW'(1);
        end else begin
          num     <= energy[idx[1:0]];
          divisor <= (count[idx[1:0]] == '0) ? CW'(1) : count[idx[1:0]];
        end
      end
      amra_pkg::ST_DIV: begin
        num <= num_next;
        rem <= rem_next;
        if (step == 6'(amra_pkg::DIV_STEPS - 1)) begin
          root_v   <= num_next[MW-1:0];
          root_res <= '0;
          root_bit <= 32'h4000_0000;
          if (idx < amra_pkg::JOB_MIX) begin
            speaking[idx[1:0]] <= num_next[MW-1:0] > speak_thr;
          end
        end
      end
      amra_pkg::ST_SQRT: begin
        if (step == 6'(amra_pkg::SQRT_STEPS - 1) && idx == amra_pkg::JOB_MIX) begin
          mix_rms  <= root_res_next[RW-1:0];
          // Peak was updated when the mix division finished.
          root_v   <= peak_ms;
          root_res <= '0;
          root_bit <= 32'h4000_0000;
        end else begin
          root_v   <= root_v_next;
          root_res <= root_res_next;
          root_bit <= root_bit >> 2;
          if (step == 6'(amra_pkg::SQRT_STEPS - 1)) begin
            if (idx < amra_pkg::JOB_MIX) begin
              rms[idx[1:0]] <= root_res_next[RW-1:0];
            end else begin
              peak_rms <= root_res_next[RW-1:0];
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Level fields read zero on words that do not end a tick.
  always_comb begin
    m_tdata         = '0;
    m_tdata[15:0]   = mixed_out;
    m_tlast         = tick_done;
    if (tick_done) begin
      m_tdata[19:16]   = speaking;
      m_tdata[35:20]   = rms[0];
      m_tdata[51:36]   = rms[1];
      m_tdata[67:52]   = rms[2];
      m_tdata[83:68]   = rms[3];
      m_tdata[99:84]   = mix_rms;
      m_tdata[115:100] = peak_rms;
    end
  end

endmodule
`default_nettype wire
